FILE: rtl/core/sequential_list_engine_unit_macros.svh
// assertion helpers for the list engine
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH
`define SLE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("list engine check failed");
`define SLE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("list engine check failed");
`else
`define SLE_ASSERT_IMP(label, ante, cons)
`define SLE_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/sle_pkg.sv
package sle_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOCATE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [6:0]         position;
        logic signed [31:0] entry_key;
        logic [31:0]        entry_payload;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [6:0]         found_position;
        logic signed [31:0] read_key;
        logic [31:0]        read_payload;
        logic [6:0]         entry_count;
    } res_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [6:0] pos;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FIN
    } state_t;

endpackage

FILE: rtl/core/sequential_list_engine_unit.sv
// insert and remove: carried out in the exec state once the output register is free; one command at a time
// locate and read: the cell chain rotates once around past the head cell in the scan state; the fin state
// then loads the result once the output register is free
// a new command is taken while the previous result still waits in the output register
// reset clears the entry count and control state; cell contents are left as they are
module sequential_list_engine_unit import sle_pkg::*; #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  cmd_t s_item,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_item
);

`include "sequential_list_engine_unit_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam int PW = (CW > 7) ? CW : 7;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg;
    logic [CW-1:0]           count_reg, count_after;
    logic [SW-1:0]           step_reg;
    logic                    scan_hit_reg;
    logic [6:0]              scan_pos_reg;
    logic signed [31:0]      scan_key_reg;
    logic [PAYLOAD_BITS-1:0] scan_pay_reg;
    logic                    m_valid_reg;
    res_t                    m_item_reg, res_next;

    logic                    out_free, ins_ok, rem_ok, scan_clear, res_load, last_step;
    logic                    in_list;
    logic [PW-1:0]           pos_ext, count_ext, step_ext, slot_ext, count_after_ext;
    cell_ctrl_t              cell_ctrl;

    logic signed [31:0]      key_chain [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_chain [CAPACITY];

    assign out_free  = !m_valid_reg || m_ready;
    assign pos_ext   = PW'(cmd_reg.position);
    assign count_ext = PW'(count_reg);
    assign ins_ok    = (count_reg < CW'(CAPACITY)) && (pos_ext != '0)
                       && (pos_ext <= count_ext + PW'(1));
    assign rem_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
    assign step_ext  = PW'(step_reg);
    assign slot_ext  = step_ext + PW'(1);
    assign in_list   = step_ext < count_ext;
    assign last_step = step_reg == SW'(CAPACITY - 1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd_reg.command == CMD_LOCATE || cmd_reg.command == CMD_READ) begin
                    state_next = ST_SCAN;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (last_step) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready       = 1'b0;
        scan_clear    = 1'b0;
        res_load      = 1'b0;
        cell_ctrl.op  = CELL_HOLD;
        cell_ctrl.pos = cmd_reg.position;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: begin
                if (cmd_reg.command == CMD_LOCATE || cmd_reg.command == CMD_READ) begin
                    scan_clear = 1'b1;
                end else if (out_free) begin
                    res_load = 1'b1;
                    if (cmd_reg.command == CMD_INSERT && ins_ok) begin
                        cell_ctrl.op = CELL_INSERT;
                    end else if (cmd_reg.command == CMD_REMOVE && rem_ok) begin
                        cell_ctrl.op = CELL_REMOVE;
                    end
                end
            end
            ST_SCAN: cell_ctrl.op = CELL_ROTATE;
            ST_FIN:  res_load = out_free;
            default: s_ready = 1'b0;
        endcase
    end

    always_comb begin
        case (cell_ctrl.op)
            CELL_INSERT: count_after = count_reg + CW'(1);
            CELL_REMOVE: count_after = count_reg - CW'(1);
            default:     count_after = count_reg;
        endcase
    end

    assign count_after_ext = PW'(count_after);

    always_comb begin
        res_next                = '0;
        res_next.entry_count    = count_after_ext[6:0];
        case (cmd_reg.command)
            CMD_INSERT: res_next.ok = ins_ok;
            CMD_REMOVE: res_next.ok = rem_ok;
            CMD_LOCATE: begin
                res_next.ok             = scan_hit_reg;
                res_next.found_position = scan_pos_reg;
            end
            default: begin
                res_next.ok           = scan_hit_reg;
                res_next.read_key     = scan_key_reg;
                res_next.read_payload = 32'(scan_pay_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_after;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_item;
        end
        if (res_load) begin
            m_item_reg <= res_next;
        end
        if (scan_clear) begin
            step_reg     <= '0;
            scan_hit_reg <= 1'b0;
            scan_pos_reg <= '0;
            scan_key_reg <= '0;
            scan_pay_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            step_reg <= step_reg + SW'(1);
            // head cell holds the entry at slot step+1 during this pass
            if (cmd_reg.command == CMD_LOCATE) begin
                if (!scan_hit_reg && in_list && key_chain[0] == cmd_reg.entry_key) begin
                    scan_hit_reg <= 1'b1;
                    scan_pos_reg <= slot_ext[6:0];
                end
            end else if (in_list && slot_ext == pos_ext) begin
                scan_hit_reg <= 1'b1;
                scan_key_reg <= key_chain[0];
                scan_pay_reg <= pay_chain[0];
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [31:0]      lower_key, upper_key;
        logic [PAYLOAD_BITS-1:0] lower_pay, upper_pay;

        if (i == 0) begin : g_first
            assign lower_key = cmd_reg.entry_key;
            assign lower_pay = cmd_reg.entry_payload[PAYLOAD_BITS-1:0];
        end else begin : g_mid_lo
            assign lower_key = key_chain[i-1];
            assign lower_pay = pay_chain[i-1];
        end

        // last cell wraps to the head so the chain can rotate
        if (i == CAPACITY - 1) begin : g_last
            assign upper_key = key_chain[0];
            assign upper_pay = pay_chain[0];
        end else begin : g_mid_hi
            assign upper_key = key_chain[i+1];
            assign upper_pay = pay_chain[i+1];
        end

        sle_cell #(
            .INDEX        (i),
            .IDXW         (PW),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .aclk          (aclk),
            .ctrl          (cell_ctrl),
            .new_key       (cmd_reg.entry_key),
            .new_payload   (cmd_reg.entry_payload[PAYLOAD_BITS-1:0]),
            .lower_key     (lower_key),
            .lower_payload (lower_pay),
            .upper_key     (upper_key),
            .upper_payload (upper_pay),
            .key           (key_chain[i]),
            .payload       (pay_chain[i])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `SLE_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(CAPACITY))
    `SLE_ASSERT_NXT(a_accept_exec, s_valid && s_ready, state_reg == ST_EXEC)
    `SLE_ASSERT_NXT(a_scan_end, state_reg == ST_SCAN && last_step, state_reg == ST_FIN)
    `SLE_ASSERT_IMP(a_count_only_edit, state_reg != ST_EXEC, count_after == count_reg)

endmodule

FILE: rtl/core/sle_cell.sv
module sle_cell import sle_pkg::*; #(
    parameter int INDEX        = 0,
    parameter int IDXW         = 7,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic signed [31:0]      new_key,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    input  logic signed [31:0]      lower_key,
    input  logic [PAYLOAD_BITS-1:0] lower_payload,
    input  logic signed [31:0]      upper_key,
    input  logic [PAYLOAD_BITS-1:0] upper_payload,
    output logic signed [31:0]      key,
    output logic [PAYLOAD_BITS-1:0] payload
);

    // 1-based list slot this cell holds
    localparam logic [IDXW-1:0] SLOT = IDXW'(INDEX + 1);

    logic signed [31:0]      key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic [IDXW-1:0]         pos_ext;

    assign pos_ext = IDXW'(ctrl.pos);

    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        unique case (ctrl.op)
            CELL_INSERT: begin
                if (SLOT > pos_ext) begin
                    key_next     = lower_key;
                    payload_next = lower_payload;
                end else if (SLOT == pos_ext) begin
                    key_next     = new_key;
                    payload_next = new_payload;
                end
            end
            CELL_REMOVE: begin
                if (SLOT >= pos_ext) begin
                    key_next     = upper_key;
                    payload_next = upper_payload;
                end
            end
            CELL_ROTATE: begin
                key_next     = upper_key;
                payload_next = upper_payload;
            end
            default: begin
                key_next     = key_reg;
                payload_next = payload_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule
